// ===== sv/acbc_pkg.sv =====
// Package for the AES-CBC block cipher: constants, S-box tables and round helpers.
package acbc_pkg;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_KEY0  = 3'd1;
    localparam logic [2:0] CFG_KEY1  = 3'd2;
    localparam logic [2:0] CFG_KEY2  = 3'd3;
    localparam logic [2:0] CFG_KEY3  = 3'd4;
    localparam logic [2:0] CFG_IVU   = 3'd5;
    localparam logic [2:0] CFG_IVL   = 3'd6;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [0:0] OP_ENC = 1'b0;
    localparam logic [0:0] OP_DEC = 1'b1;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic t_byte xt(input t_byte b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_word sub_word(input t_word w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte k of the state sits at bits [127-8k -: 8].
    function automatic t_block sub_shift(input t_block s, input logic inv);
        t_block o;
        int     src;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                o[127 - 8*(r + 4*c) -: 8] = inv ? ISBOX[s[127 - 8*(r + 4*src) -: 8]]
                                                : SBOX[s[127 - 8*(r + 4*src) -: 8]];
            end
        end
        sub_shift = o;
    endfunction

    function automatic t_block mix(input t_block s, input logic inv);
        t_block o;
        t_byte  a0, a1, a2, a3, u, v;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            if (inv) begin
                // Pre-step reduces inverse mix to the forward one.
                u = xt(xt(a0 ^ a2));
                v = xt(xt(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            o[127 - 32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[119 - 32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[111 - 32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[103 - 32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        mix = o;
    endfunction

endpackage

// ===== sv/acbc_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module acbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/aes_cbc_block_cipher.sv =====
// AES-CBC block cipher top level: sequencer, key expansion, round datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  input   | in        | i_valid / o_stall  | i_opcode, i_block_upper/lower, i_first_block
//  output  | out       | o_valid / i_stall  | o_result_upper, o_result_lower
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Key expansion, on a first_block request, makes one key word per cycle from a
// single S-box word unit, 4*(Nr+1) words in all (44, 52 or 60).
// Each round then reads four words of the round-key RAM, one word a cycle,
// through the registered read, after which the round is applied.
// A result is ready once its rounds are done, plus the expansion on a restart;
// the next request is taken only after the result loads and the sequencer idles.
// Reset clears the chain, the configuration and the sequencer; the RAM is not cleared.
// A result waits in the output register while i_stall is high; one more request
// may be taken meanwhile, and it is held in its last step until the register frees.
module aes_cbc_block_cipher #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [0:0]  i_opcode,
    input  logic [63:0] i_block_upper,
    input  logic [63:0] i_block_lower,
    input  logic [0:0]  i_first_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_upper,
    output logic [63:0] o_result_lower,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import acbc_pkg::*;

    localparam int AW = $clog2(ROUND_KEY_WORDS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEXP = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]   r_state;
    logic [1:0]   r_mode;
    logic [63:0]  r_key [4];
    logic [127:0] r_iv;
    logic [127:0] r_chain;
    logic [127:0] r_st;
    logic [127:0] r_blk;
    logic [127:0] r_res;
    logic         r_dec;
    logic         r_ovalid;

    // key expansion
    logic [5:0]   r_ki;       // word index being made
    logic [31:0]  r_win [8];  // last Nk words, newest at index 0
    logic [2:0]   r_kmod;     // i mod Nk
    logic [7:0]   r_rcon;

    // round sequencing
    logic [3:0]   r_rnd;      // rounds done
    logic [2:0]   r_wsel;     // word fetch phase 0..4
    logic [127:0] r_rk;
    logic [5:0]   r_raddr;
    logic         r_rk_ok;    // last read address lies inside the store

    logic [3:0]   nr;
    logic [2:0]   nk;
    logic [5:0]   total;
    always_comb begin
        case (r_mode)
            MODE_128: begin nr = 4'd10; nk = 3'd4; end
            MODE_192: begin nr = 4'd12; nk = 3'd6; end
            default:  begin nr = 4'd14; nk = 3'd0; end // 0 stands for eight
        endcase
        total = {nr, 2'b00} + 6'd4;
    end

    logic [31:0] kw_key, kw_new, kw_t, kw_old;
    logic [3:0]  nkw;
    assign nkw = (nk == 3'd0) ? 4'd8 : {1'b0, nk};
    always_comb begin
        kw_key = r_key[r_ki[2:1]][(r_ki[0] ? 31 : 63) -: 32];
        kw_old = r_win[3'(nkw - 4'd1)];
        kw_t   = r_win[0];
        if (r_kmod == 3'd0) begin
            kw_t = sub_word({kw_t[23:0], kw_t[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nkw == 4'd8 && r_kmod == 3'd4) begin
            kw_t = sub_word(kw_t);
        end
        kw_new = ({2'b0, r_ki} < {4'b0, nkw}) ? kw_key : (kw_old ^ kw_t);
    end

    logic        ram_we;
    logic [31:0] ram_rd;
    acbc_ram #(.WIDTH(32), .DEPTH(ROUND_KEY_WORDS)) u_rk (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ki[AW-1:0]),
        .i_wdata (kw_new),
        .i_raddr (r_raddr[AW-1:0]),
        .o_rdata (ram_rd)
    );
    assign ram_we = (r_state == S_KEXP) && ({26'b0, r_ki} < ROUND_KEY_WORDS);

    // Words past the end of the store read as zero.
    always_ff @(posedge i_clk) begin
        r_rk_ok <= ({26'b0, r_raddr} < ROUND_KEY_WORDS);
    end

    logic [31:0] rk_word;
    assign rk_word = r_rk_ok ? ram_rd : 32'h0;

    logic acc_in, acc_out, out_load;
    assign o_stall     = (r_state != S_IDLE);
    assign acc_in      = i_valid && (r_state == S_IDLE);
    assign acc_out     = r_ovalid && !i_stall;
    assign out_load    = (r_state == S_OUT) && (!r_ovalid || acc_out);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_result_upper = r_res[127:64];
    assign o_result_lower = r_res[63:0];

    // Round-key word for a round number, fetched in order of the round.
    logic [3:0] rk_round;
    assign rk_round = r_dec ? (nr - r_rnd) : r_rnd;

    logic [127:0] rk_full, st_round, st_next;
    assign rk_full = {r_rk[95:0], rk_word};
    always_comb begin
        st_round = '0;
        if (r_rnd == 4'd0) begin
            st_next = r_st ^ rk_full;
        end else if (!r_dec) begin
            st_round = sub_shift(r_st, 1'b0);
            if (r_rnd != nr) begin
                st_round = mix(st_round, 1'b0);
            end
            st_next = st_round ^ rk_full;
        end else begin
            st_round = sub_shift(r_st, 1'b1) ^ rk_full;
            st_next  = (r_rnd != nr) ? mix(st_round, 1'b1) : st_round;
        end
    end

    logic [5:0] fetch_addr;
    assign fetch_addr = {rk_round, 2'b00} + {3'b0, r_wsel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_128;
            r_key    <= '{default: '0};
            r_iv     <= '0;
            r_chain  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Raise valid when a result loads; drop it when the result leaves.
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (acc_out) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE: r_mode <= i_cfg_data[1:0];
                    CFG_KEY0: r_key[0] <= i_cfg_data;
                    CFG_KEY1: r_key[1] <= i_cfg_data;
                    CFG_KEY2: r_key[2] <= i_cfg_data;
                    CFG_KEY3: r_key[3] <= i_cfg_data;
                    CFG_IVU:  r_iv[127:64] <= i_cfg_data;
                    CFG_IVL:  r_iv[63:0] <= i_cfg_data;
                    default:  ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_dec  <= i_opcode == OP_DEC;
                        r_blk  <= {i_block_upper, i_block_lower};
                        r_ki   <= '0;
                        r_kmod <= '0;
                        r_rcon <= 8'h01;
                        if (i_first_block == 1'b1) begin
                            r_chain <= r_iv;
                            r_state <= S_KEXP;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_KEXP: begin
                    for (int j = 7; j > 0; j--) begin
                        r_win[j] <= r_win[j-1];
                    end
                    r_win[0] <= kw_new;
                    if ({2'b0, r_ki} >= {4'b0, nkw}) begin
                        r_kmod <= (r_kmod == 3'(nkw - 4'd1)) ? 3'd0 : r_kmod + 3'd1;
                        if (r_kmod == 3'd0) begin
                            r_rcon <= xt(r_rcon);
                        end
                    end else if ({2'b0, r_ki} == {4'b0, nkw} - 8'd1) begin
                        r_kmod <= 3'd0;
                    end
                    r_ki <= r_ki + 6'd1;
                    if (r_ki == total - 6'd1) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_st    <= r_dec ? r_blk : (r_blk ^ r_chain);
                    r_rnd   <= '0;
                    r_wsel  <= '0;
                    r_raddr <= r_dec ? {nr, 2'b00} : 6'd0;
                    r_state <= S_RND;
                end
                S_RND: begin
                    // Phase 0 issues word 0's read; phases 1..4 collect words.
                    if (r_wsel != 3'd4) begin
                        r_raddr <= fetch_addr + 6'd1;
                    end
                    if (r_wsel != 3'd0) begin
                        r_rk <= rk_full;
                    end
                    if (r_wsel == 3'd4) begin
                        r_st   <= st_next;
                        r_wsel <= '0;
                        if (r_rnd == nr) begin
                            r_state <= S_OUT;
                        end else begin
                            r_rnd   <= r_rnd + 4'd1;
                            r_raddr <= r_dec ? {nr - r_rnd - 4'd1, 2'b00}
                                             : {r_rnd + 4'd1, 2'b00};
                        end
                    end else begin
                        r_wsel <= r_wsel + 3'd1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_dec) begin
                            r_res   <= r_st ^ r_chain;
                            r_chain <= r_blk;
                        end else begin
                            r_res   <= r_st;
                            r_chain <= r_st;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== bench/aes_cbc_block_cipher_test.sv =====
// Self-checking testbench for the AES-CBC block cipher: chained requests against a predictor.
module aes_cbc_block_cipher_test;
    import acbc_pkg::*;

    localparam logic [1:0] MODE_256_ALT = 2'd3;
    localparam int         STALL_LIMIT  = 20000;
    localparam int         RX_HOLD_LEN  = 400;

    typedef logic [7:0] t_state [16];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [0:0]  i_opcode;
    logic [63:0] i_block_upper;
    logic [63:0] i_block_lower;
    logic [0:0]  i_first_block;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_upper;
    logic [63:0] o_result_lower;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    aes_cbc_block_cipher i_dut (.*);

    // Predictor state: configuration copy, expanded schedule and chain.
    logic [7:0]   fwd_sbox [256];
    logic [7:0]   rev_sbox [256];
    logic [1:0]   key_mode;
    logic [63:0]  key_words [4];
    logic [127:0] iv_value;
    logic [31:0]  schedule [60];
    logic [127:0] chain_block;

    logic [127:0] pending_blocks [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           rx_hold_req;
    bit           no_idle;

    // 2-unit period clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc ^= a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // Build the S-box from the field inverse and the affine map.
    task automatic build_sboxes();
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            v = 8'h01;
            p = x[7:0];
            for (int e = 0; e < 8; e++) begin
                if (e != 0) begin
                    v = gf_mul(v, p);
                end
                p = gf_mul(p, p);
            end
            s = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
            fwd_sbox[x] = s;
            rev_sbox[s] = x[7:0];
        end
    endtask

    function automatic int key_nk();
        return (key_mode == MODE_128) ? 4 : ((key_mode == MODE_192) ? 6 : 8);
    endfunction

    function automatic logic [31:0] sub_word32(logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int         nk;
        int         total;
        logic [31:0] t;
        logic [7:0] rcon;
        nk = key_nk();
        total = 4 * (nk + 7);
        rcon = 8'h01;
        for (int i = 0; i < nk; i++) begin
            schedule[i] = (i % 2 == 1) ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
        end
        for (int i = nk; i < total; i++) begin
            t = schedule[i - 1];
            if (i % nk == 0) begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_mul(rcon, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = sub_word32(t);
            end
            schedule[i] = schedule[i - nk] ^ t;
        end
    endfunction

    function automatic t_state add_key(t_state s, int round);
        logic [31:0] w;
        for (int k = 0; k < 16; k++) begin
            w = schedule[4 * round + k / 4];
            s[k] ^= w[31 - 8 * (k % 4) -: 8];
        end
        return s;
    endfunction

    function automatic t_state sub_shift_rows(t_state s, bit inv);
        t_state t;
        int     src;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[r + 4 * c] = inv ? rev_sbox[s[r + 4 * src]] : fwd_sbox[s[r + 4 * src]];
            end
        end
        return t;
    endfunction

    function automatic t_state mix_cols(t_state s, bit inv);
        logic [7:0] coef [4];
        logic [7:0] col  [4];
        logic [7:0] acc;
        if (inv) begin
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        end else begin
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                col[r] = s[4 * c + r];
            end
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    acc ^= gf_mul(coef[(k + 4 - r) % 4], col[k]);
                end
                s[4 * c + r] = acc;
            end
        end
        return s;
    endfunction

    // Run the full cipher or inverse cipher over one 128-bit block.
    function automatic logic [127:0] aes_core(logic [127:0] blk, bit inv);
        t_state       s;
        int           nr;
        logic [127:0] out;
        nr = key_nk() + 6;
        for (int k = 0; k < 16; k++) begin
            s[k] = blk[127 - 8 * k -: 8];
        end
        if (!inv) begin
            s = add_key(s, 0);
            for (int r = 1; r < nr; r++) begin
                s = add_key(mix_cols(sub_shift_rows(s, 0), 0), r);
            end
            s = add_key(sub_shift_rows(s, 0), nr);
        end else begin
            s = add_key(s, nr);
            for (int r = nr - 1; r >= 1; r--) begin
                s = mix_cols(add_key(sub_shift_rows(s, 1), r), 1);
            end
            s = add_key(sub_shift_rows(s, 1), 0);
        end
        for (int k = 0; k < 16; k++) begin
            out[127 - 8 * k -: 8] = s[k];
        end
        return out;
    endfunction

    // Advance the chain by one accepted request and return the block it produces.
    function automatic logic [127:0] cbc_predict(logic [0:0] op, logic [127:0] blk,
                                                  logic [0:0] first);
        logic [127:0] res;
        if (first) begin
            expand_schedule();
            chain_block = iv_value;
        end
        if (op == OP_ENC) begin
            res = aes_core(blk ^ chain_block, 0);
            chain_block = res;
        end else begin
            res = aes_core(blk, 1) ^ chain_block;
            chain_block = blk;
        end
        return res;
    endfunction

    // Offer one request, with a random gap first, and log its prediction on acceptance.
    task automatic send_block(logic [0:0] op, logic [63:0] hi, logic [63:0] lo,
                              logic [0:0] first);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 24) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = op;
        i_block_upper = hi;
        i_block_lower = lo;
        i_first_block = first;
        do @(posedge i_clk); while (o_stall);
        pending_blocks.insert(pending_blocks.size(), cbc_predict(op, {hi, lo}, first));
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE: key_mode = data[1:0];
            CFG_KEY0: key_words[0] = data;
            CFG_KEY1: key_words[1] = data;
            CFG_KEY2: key_words[2] = data;
            CFG_KEY3: key_words[3] = data;
            CFG_IVU:  iv_value[127:64] = data;
            CFG_IVL:  iv_value[63:0] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drain all outstanding results, then let the core settle.
    task automatic wait_drained();
        drop_valid();
        while (pending_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic load_setup(logic [1:0] mode, logic [63:0] k0, logic [63:0] k1,
                              logic [63:0] k2, logic [63:0] k3,
                              logic [63:0] ivu, logic [63:0] ivl);
        wait_drained();
        write_reg(CFG_MODE, {62'd0, mode});
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_IVU, ivu);
        write_reg(CFG_IVL, ivl);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_random_setup();
        load_setup(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64(),
                   rand64(), rand64());
    endtask

    // Send one message: restart on the first request, random ops and data after it.
    task automatic send_message(int len);
        for (int n = 0; n < len; n++) begin
            send_block(1'($urandom_range(1)), rand64(), rand64(), n == 0);
        end
    endtask

    // Standard test vectors, data extremes, all key sizes and the alias of mode three.
    task automatic test_directed();
        load_setup(MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, '0, '0);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block(OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        send_block(OP_ENC, '0, '0, 1'b0);
        send_block(OP_ENC, '1, '1, 1'b0);
        send_block(OP_DEC, '1, '0, 1'b0);
        load_setup(MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, '1, '1, '1);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block(OP_DEC, '0, '1, 1'b0);
        send_block(OP_ENC, '0, '0, 1'b1);
        load_setup(MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, 64'h18191a1b1c1d1e1f, '0, '0);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block(OP_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1);
        load_setup(MODE_256_ALT, '1, '1, '1, '1, '1, '1);
        send_block(OP_ENC, '1, '1, 1'b1);
        send_block(OP_DEC, '1, '1, 1'b0);
        load_setup(MODE_128, '0, '0, '0, '0, 64'h8000000000000001, 64'h0000000000000001);
        send_block(OP_DEC, '0, '0, 1'b1);
        send_block(OP_ENC, 64'h8000000000000000, 64'h0000000000000001, 1'b0);
    endtask

    // Random setups, mostly well-formed messages; one long stretch with no gaps.
    task automatic test_random_messages();
        for (int ph = 0; ph < 17; ph++) begin
            load_random_setup();
            no_idle = (ph == 5);
            for (int m = 0; m < 10; m++) begin
                send_message($urandom_range(1, 12));
            end
            // stray restarts mid-stream
            send_block(1'($urandom_range(1)), rand64(), rand64(), 1'b1);
            send_message($urandom_range(1, 6));
        end
        no_idle = 0;
    endtask

    // Hold the receiver off while requests keep coming so the input backs up.
    task automatic test_output_backpressure();
        load_random_setup();
        @(negedge i_clk);
        rx_hold_req = 1'b1;
        send_message(20);
        rx_hold_req = 1'b0;
    endtask

    // Pause the sender mid-message until every result is back, then resume the chain.
    task automatic test_sender_pause();
        load_random_setup();
        send_message(5);
        wait_drained();
        for (int n = 0; n < 6; n++) begin
            send_block(1'($urandom_range(1)), rand64(), rand64(), 1'b0);
        end
    endtask

    // Receiver: random stalls, and one long counted hold once it is requested.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !hold_done) begin
                hold_left = RX_HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                i_stall = !no_idle && ($urandom_range(99) < 24);
            end
        end
    end

    // Compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result %h_%h", $time, o_result_upper, o_result_lower);
                error_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (o_result_upper !== want[127:64]) begin
                    $display("%0t: result_upper expected %h actual %h",
                             $time, want[127:64], o_result_upper);
                    error_count++;
                end
                if (o_result_lower !== want[63:0]) begin
                    $display("%0t: result_lower expected %h actual %h",
                             $time, want[63:0], o_result_lower);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_ENC;
        i_block_upper = '0;
        i_block_lower = '0;
        i_first_block = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = '0;
        key_mode = MODE_128;
        key_words = '{default: '0};
        iv_value = '0;
        schedule = '{default: '0};
        chain_block = '0;
        rx_hold_req = 1'b0;
        no_idle = 0;
        build_sboxes();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_messages();
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (150) @(posedge i_clk);

        if (error_count == 0 && pending_blocks.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== aes_cbc_block_cipher.f =====
sv/acbc_pkg.sv
sv/acbc_ram.sv
sv/aes_cbc_block_cipher.sv
bench/aes_cbc_block_cipher_test.sv
